[hdl/json_token_serializer_assert.svh]
// Assertion macros shared by the serialiser modules.
`ifndef JSON_TOKEN_SERIALIZER_ASSERT_SVH
`define JSON_TOKEN_SERIALIZER_ASSERT_SVH

// The condition must hold at every rising edge outside reset.
`define JTS_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// The consequent must hold at the same edge as the antecedent.
`define JTS_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold at the edge after the antecedent.
`define JTS_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hdl/jts_pkg.sv]
// Types, token codes, characters and helper functions of the JSON serialiser.
package jts_pkg;

	localparam logic [2:0] KIND_OBJ_OPEN  = 3'd0;
	localparam logic [2:0] KIND_OBJ_CLOSE = 3'd1;
	localparam logic [2:0] KIND_ARR_OPEN  = 3'd2;
	localparam logic [2:0] KIND_ARR_CLOSE = 3'd3;
	localparam logic [2:0] KIND_STR_OPEN  = 3'd4;
	localparam logic [2:0] KIND_STR_BYTE  = 3'd5;
	localparam logic [2:0] KIND_STR_CLOSE = 3'd6;
	localparam logic [2:0] KIND_INT       = 3'd7;

	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6e;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CTRL_MAX  = 8'h1f;
	localparam logic [7:0] NIB_MASK  = 8'h0f;

	typedef struct packed {
		logic odd;
		logic items;
		logic array;
	} lvl_t;

	typedef struct packed {
		logic            err;
		logic [5:0][7:0] pre;
		logic [2:0]      pre_n;
		logic [31:0]     mag;
		logic [3:0]      dig_n;
	} plan_t;

	function automatic logic [33:0] pow10(input logic [3:0] k);
		logic [33:0] r;
		case (k)
			4'd0: r = 34'd1;
			4'd1: r = 34'd10;
			4'd2: r = 34'd100;
			4'd3: r = 34'd1000;
			4'd4: r = 34'd10000;
			4'd5: r = 34'd100000;
			4'd6: r = 34'd1000000;
			4'd7: r = 34'd10000000;
			4'd8: r = 34'd100000000;
			4'd9: r = 34'd1000000000;
			default: r = 34'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] r;
		r = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h57 + {4'd0, v});
		return r;
	endfunction

endpackage

[hdl/jts_front.sv]
// Input register, nesting stack and byte plan for each token.
module jts_front #(
	parameter int MAX_NESTING = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [39:0]       s_tdata,
	input  logic [2:0]        s_tuser,
	input  logic              take,
	output logic              plan_valid,
	output jts_pkg::plan_t    plan
);

	localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
	localparam int DW = $clog2(MAX_NESTING + 1);

	logic              valid_s1_q;
	logic [2:0]        kind_s1;
	logic [7:0]        tb_s1;
	logic [31:0]       iv_s1;
	logic [DW-1:0]     depth_q;
	jts_pkg::lvl_t     top_q;
	jts_pkg::lvl_t     below_q;
	jts_pkg::lvl_t     mem [MAX_NESTING];

	logic              load;
	logic              is_open;
	logic              is_close;
	logic              wants_sep;
	logic              err;
	logic              sep_v;
	logic [7:0]        sep_b;
	jts_pkg::lvl_t     top_upd;
	logic [5:0][7:0]   body;
	logic [2:0]        body_n;
	logic [31:0]       mag;
	logic [8:0]        ge;

	assign s_tready   = !valid_s1_q || take;
	assign plan_valid = valid_s1_q;
	assign load       = valid_s1_q && take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1_q <= 1'b1;
		end else if (load) begin
			valid_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			tb_s1   <= s_tdata[7:0];
			iv_s1   <= s_tdata[39:8];
		end
	end

	always_comb begin
		is_open   = (kind_s1 == jts_pkg::KIND_OBJ_OPEN) || (kind_s1 == jts_pkg::KIND_ARR_OPEN);
		is_close  = (kind_s1 == jts_pkg::KIND_OBJ_CLOSE) || (kind_s1 == jts_pkg::KIND_ARR_CLOSE);
		wants_sep = is_open || (kind_s1 == jts_pkg::KIND_STR_OPEN) ||
			(kind_s1 == jts_pkg::KIND_INT);
		err = (is_open && (depth_q == DW'(MAX_NESTING))) || (is_close && (depth_q == '0));
		sep_v   = 1'b0;
		sep_b   = jts_pkg::CH_COMMA;
		top_upd = top_q;
		if (wants_sep && !err && (depth_q != '0)) begin
			sep_v = top_q.items;
			if (!top_q.array && top_q.odd) begin
				sep_b = jts_pkg::CH_COLON;
			end
			top_upd.items = 1'b1;
			top_upd.odd   = !top_q.odd;
		end
		mag = iv_s1[31] ? (32'd0 - iv_s1) : iv_s1;
		for (int i = 1; i < 10; i++) begin
			ge[i-1] = {2'b00, mag} >= jts_pkg::pow10(4'(i));
		end
		body   = '0;
		body_n = 3'd1;
		case (kind_s1)
			jts_pkg::KIND_OBJ_OPEN:  body[0] = jts_pkg::CH_LBRACE;
			jts_pkg::KIND_OBJ_CLOSE: body[0] = jts_pkg::CH_RBRACE;
			jts_pkg::KIND_ARR_OPEN:  body[0] = jts_pkg::CH_LBRACK;
			jts_pkg::KIND_ARR_CLOSE: body[0] = jts_pkg::CH_RBRACK;
			jts_pkg::KIND_STR_OPEN:  body[0] = jts_pkg::CH_QUOTE;
			jts_pkg::KIND_STR_CLOSE: body[0] = jts_pkg::CH_QUOTE;
			jts_pkg::KIND_STR_BYTE: begin
				body[0] = jts_pkg::CH_BSLASH;
				body_n  = 3'd2;
				case (tb_s1)
					jts_pkg::CH_QUOTE, jts_pkg::CH_BSLASH, jts_pkg::CH_SLASH: body[1] = tb_s1;
					8'h08: body[1] = jts_pkg::CH_LOW_B;
					8'h0c: body[1] = jts_pkg::CH_LOW_F;
					8'h0a: body[1] = jts_pkg::CH_LOW_N;
					8'h0d: body[1] = jts_pkg::CH_LOW_R;
					8'h09: body[1] = jts_pkg::CH_LOW_T;
					default: begin
						if (tb_s1 <= jts_pkg::CTRL_MAX) begin
							body[1] = jts_pkg::CH_LOW_U;
							body[2] = jts_pkg::CH_ZERO;
							body[3] = jts_pkg::CH_ZERO;
							body[4] = jts_pkg::hex_char(tb_s1[7:4]);
							body[5] = jts_pkg::hex_char(4'(tb_s1 & jts_pkg::NIB_MASK));
							body_n  = 3'd6;
						end else begin
							body[0] = tb_s1;
							body_n  = 3'd1;
						end
					end
				endcase
			end
			default: begin
				body[0] = jts_pkg::CH_MINUS;
				body_n  = {2'b00, iv_s1[31]};
			end
		endcase
		plan.err   = err;
		plan.mag   = mag;
		plan.dig_n = 4'd0;
		if (err) begin
			plan.pre   = '0;
			plan.pre_n = 3'd1;
		end else begin
			if (kind_s1 == jts_pkg::KIND_INT) begin
				plan.dig_n = 4'd1 + 4'($countones(ge));
			end
			plan.pre_n = body_n + {2'b00, sep_v};
			if (sep_v) begin
				plan.pre[0] = sep_b;
				for (int i = 1; i < 6; i++) begin
					plan.pre[i] = body[i-1];
				end
			end else begin
				plan.pre = body;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (load && !err) begin
			if (is_open) begin
				depth_q <= depth_q + DW'(1);
			end else if (is_close) begin
				depth_q <= depth_q - DW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !err) begin
			if (is_open) begin
				top_q   <= '{odd: 1'b0, items: 1'b0,
					array: (kind_s1 == jts_pkg::KIND_ARR_OPEN)};
				below_q <= top_upd;
				if (depth_q != '0) begin
					mem[AW'(depth_q - DW'(1))] <= top_upd;
				end
			end else if (is_close) begin
				top_q   <= below_q;
				below_q <= mem[AW'(depth_q - DW'(3))];
			end else begin
				top_q <= top_upd;
			end
		end
	end

	`include "json_token_serializer_assert.svh"

	`JTS_ASSERT(a_depth_bound, depth_q <= DW'(MAX_NESTING))
	`JTS_IMPLY(a_err_single, plan_valid && plan.err, plan.pre_n == 3'd1 && plan.dig_n == 4'd0)

endmodule

[hdl/jts_emit.sv]
// Result register that sends the planned bytes and the decimal digits one a cycle while m_tready is high.
module jts_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              plan_valid,
	input  jts_pkg::plan_t    plan,
	output logic              take,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast,
	output logic [0:0]        m_tuser
);

	logic              pl_valid_q;
	logic              err_q;
	logic [5:0][7:0]   pre_q;
	logic [2:0]        pre_n_q;
	logic [2:0]        idx_q;
	logic [31:0]       rem_q;
	logic [3:0]        dig_n_q;

	logic              in_pre;
	logic [3:0]        kdig;
	logic [33:0]       cand [10];
	logic [8:0]        ge;
	logic [3:0]        digit;
	logic [33:0]       sub;
	logic              fire;

	always_comb begin
		in_pre = idx_q < pre_n_q;
		kdig   = dig_n_q - 4'd1;
		cand[0] = '0;
		for (int j = 1; j < 10; j++) begin
			cand[j]  = jts_pkg::pow10(kdig) * 34'(j);
			ge[j-1]  = {2'b00, rem_q} >= cand[j];
		end
		digit = 4'($countones(ge));
		sub   = cand[digit];
		if (in_pre) begin
			m_tdata = pre_q[idx_q];
			m_tlast = (idx_q == (pre_n_q - 3'd1)) && (dig_n_q == 4'd0);
		end else begin
			m_tdata = jts_pkg::CH_ZERO + {4'd0, digit};
			m_tlast = dig_n_q == 4'd1;
		end
	end

	assign m_tvalid   = pl_valid_q;
	assign m_tuser[0] = err_q;
	assign fire       = pl_valid_q && m_tready;
	assign take       = !pl_valid_q || (fire && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_valid_q <= 1'b0;
			idx_q      <= '0;
			dig_n_q    <= '0;
		end else if (plan_valid && take) begin
			pl_valid_q <= 1'b1;
			idx_q      <= '0;
			dig_n_q    <= plan.dig_n;
		end else if (fire) begin
			if (m_tlast) begin
				pl_valid_q <= 1'b0;
			end else if (in_pre) begin
				idx_q <= idx_q + 3'd1;
			end else begin
				dig_n_q <= dig_n_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (plan_valid && take) begin
			err_q   <= plan.err;
			pre_q   <= plan.pre;
			pre_n_q <= plan.pre_n;
			rem_q   <= plan.mag;
		end else if (fire && !m_tlast && !in_pre) begin
			rem_q <= rem_q - sub[31:0];
		end
	end

	`include "json_token_serializer_assert.svh"

	`JTS_IMPLY(a_err_is_last, m_tvalid && m_tuser[0], m_tlast && m_tdata == 8'd0)
	`JTS_ASSERT(a_digits_bound, dig_n_q <= 4'd10)
	`JTS_NEXT(a_digit_advances, fire && !m_tlast && !in_pre, dig_n_q == $past(dig_n_q) - 4'd1)

endmodule

[hdl/json_token_serializer.sv]
// Top level: minified JSON writer turning tokens into a byte stream.
// A token passes the input register, then the result register, before its first byte is shown.
// One output byte per cycle while m_tready is high.
// The input register takes the next token while the current one is still being sent.
// Decimal digits come from a power-of-ten compare unit, one digit per cycle while m_tready is high.
// Reset clears the nesting depth and both valid flags; stack entries need no clearing.
module json_token_serializer #(
	parameter int MAX_NESTING = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // text_byte[7:0], int_value[39:8]
	input  logic [2:0]  s_tuser,   // kind[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic        m_tlast,
	output logic [0:0]  m_tuser    // error[0]
);

	logic              take;
	logic              plan_valid;
	jts_pkg::plan_t    plan;

	jts_front #(.MAX_NESTING(MAX_NESTING)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.take       (take),
		.plan_valid (plan_valid),
		.plan       (plan)
	);

	jts_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.plan_valid (plan_valid),
		.plan       (plan),
		.take       (take),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule
